/* rtl/qgi_pkg.sv */
// Shared types, constants and arithmetic helpers of the quaternion gyro integrator.
package qgi_pkg;

  // Field and datapath widths
  localparam int QW        = 32;          // quaternion component, Q2.30
  localparam int RATE_W    = 32;          // gyro rate, Q16.16
  localparam int TS_W      = 32;          // time step, unsigned Q0.32
  localparam int MA_W      = 48;          // multiplier operand A
  localparam int MB_W      = 40;          // multiplier operand B
  localparam int MP_W      = MA_W + MB_W; // multiplier product
  localparam int DIGIT_W   = 8;           // operand B bits consumed per cycle
  localparam int MUL_DIGITS = MB_W / DIGIT_W;
  localparam int MCNT_W    = $clog2(MUL_DIGITS);
  localparam int A_W       = 45;          // scaled rate, (|rate| * time_step) >> 18
  localparam int H_W       = 39;          // half angle magnitude, Q.30
  localparam int TM_W      = 40;          // update term magnitude
  localparam int ACC_W     = 44;          // unsaturated component accumulator
  localparam int SUM_W     = 63;          // sum of squares, Q.58
  localparam int ROOT_W    = 32;          // magnitude, Q.29
  localparam int RCP_W     = 40;          // reciprocal of the magnitude
  localparam int DIV_STEPS = 62;          // bits of the dividend 2^61
  localparam int DCNT_W    = $clog2(DIV_STEPS);
  localparam int SCNT_W    = $clog2(ROOT_W);

  // Arithmetic constants
  localparam logic [26:0]       DEG_TO_RAD_Q32  = 27'd74961321;
  localparam logic [SUM_W-1:0]  MIN_MAG_SQ      = 63'd28823037615171;
  localparam logic [TS_W-1:0]   TIME_STEP_RESET = 32'd21474836;
  localparam logic [QW-1:0]     QUAT_ONE        = {2'b01, {(QW-2){1'b0}}};
  localparam logic [QW-1:0]     QUAT_MAX        = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0]     QUAT_MIN        = {1'b1, {(QW-1){1'b0}}};

  // Datapath operation codes
  localparam logic [2:0] OP_RT   = 3'd0;  // |rate| * time_step
  localparam logic [2:0] OP_HD   = 3'd1;  // scaled rate * degrees-to-radians
  localparam logic [2:0] OP_TERM = 3'd2;  // quaternion component * half angle
  localparam logic [2:0] OP_SQ   = 3'd3;  // component squared
  localparam logic [2:0] OP_SQRT = 3'd4;  // square root of the sum of squares
  localparam logic [2:0] OP_DIV  = 3'd5;  // reciprocal of the magnitude
  localparam logic [2:0] OP_NORM = 3'd6;  // component * reciprocal

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       load;    // take the input beat, clear the fallback flag
    logic       start;   // start the unit that op selects
    logic       wb;      // store the result of op
    logic       fall;    // replace the quaternion with identity
    logic       finish;  // move the quaternion into the output register
    logic [2:0] op;
    logic [3:0] idx;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic done;      // the selected unit has its result
    logic low_mag;   // magnitude at most 0.01
    logic out_free;  // the output register can take a beat
  } sts_t;

  // One term of the first-order update
  typedef struct packed {
    logic [1:0] dst;   // component being updated (w, x, y, z)
    logic [1:0] src;   // component multiplied
    logic [1:0] axis;  // roll, pitch, yaw
    logic       sub;   // term is subtracted
    logic       first; // first term of its component
    logic       last;  // last term of its component
  } term_t;

  function automatic term_t term_sel(logic [3:0] idx);
    term_t t;
    t = '0;
    case (idx)
      4'd0:    t = '{2'd0, 2'd1, 2'd0, 1'b1, 1'b1, 1'b0};
      4'd1:    t = '{2'd0, 2'd2, 2'd1, 1'b1, 1'b0, 1'b0};
      4'd2:    t = '{2'd0, 2'd3, 2'd2, 1'b1, 1'b0, 1'b1};
      4'd3:    t = '{2'd1, 2'd0, 2'd0, 1'b0, 1'b1, 1'b0};
      4'd4:    t = '{2'd1, 2'd2, 2'd2, 1'b0, 1'b0, 1'b0};
      4'd5:    t = '{2'd1, 2'd3, 2'd1, 1'b1, 1'b0, 1'b1};
      4'd6:    t = '{2'd2, 2'd0, 2'd1, 1'b0, 1'b1, 1'b0};
      4'd7:    t = '{2'd2, 2'd1, 2'd2, 1'b1, 1'b0, 1'b0};
      4'd8:    t = '{2'd2, 2'd3, 2'd0, 1'b0, 1'b0, 1'b1};
      4'd9:    t = '{2'd3, 2'd0, 2'd2, 1'b0, 1'b1, 1'b0};
      4'd10:   t = '{2'd3, 2'd1, 2'd1, 1'b0, 1'b0, 1'b0};
      4'd11:   t = '{2'd3, 2'd2, 2'd0, 1'b1, 1'b0, 1'b1};
      default: t = '0;
    endcase
    return t;
  endfunction

  // Magnitude of a 32-bit two's complement value
  function automatic logic [31:0] mag32(logic [31:0] v);
    return v[31] ? 32'(~v + 32'd1) : v;
  endfunction

  // Saturate the accumulator to the component range
  function automatic logic [QW-1:0] sat_acc(logic [ACC_W-1:0] v);
    logic [ACC_W-QW:0] top;
    top = v[ACC_W-1:QW-1];
    if ((top == '0) || (top == '1)) begin
      return v[QW-1:0];
    end
    return v[ACC_W-1] ? QUAT_MIN : QUAT_MAX;
  endfunction

  // Apply a sign to a magnitude and saturate to the component range
  function automatic logic [QW-1:0] sat_mag(logic [RCP_W-1:0] m, logic neg);
    if (!neg) begin
      return (m[RCP_W-1:QW-1] != '0) ? QUAT_MAX : m[QW-1:0];
    end
    if ((m[RCP_W-1:QW] != '0) || (m[QW-1] && (m[QW-2:0] != '0))) begin
      return QUAT_MIN;
    end
    return QW'(~m[QW-1:0] + 1'b1);
  endfunction

endpackage

/* rtl/qgi_mul.sv */
// Serial multiplier that takes eight bits of operand B per cycle.
module qgi_mul import qgi_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [MA_W-1:0] a_i,
  input  logic [MB_W-1:0] b_i,
  output logic            done_o,
  output logic [MP_W-1:0] p_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [MCNT_W-1:0]   cnt_q, cnt_d;
  logic [MA_W-1:0]     a_q;
  logic [MB_W-1:0]     b_q;
  logic [MP_W-1:0]     acc_q;
  logic [MA_W+DIGIT_W-1:0] part;

  // One partial product per cycle, most significant digit first
  assign part = a_q * b_q[MB_W-1 -: DIGIT_W];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == MCNT_W'(MUL_DIGITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      b_q   <= {b_q[MB_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      acc_q <= {acc_q[MP_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}} + MP_W'(part);
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

/* rtl/qgi_sqrt.sv */
// Integer square root, one result bit per cycle.
module qgi_sqrt import qgi_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [2*ROOT_W-1:0] rad_i,
  output logic                done_o,
  output logic [ROOT_W-1:0]   root_o
);

  logic                busy_q, done_q;
  logic [SCNT_W-1:0]   cnt_q;
  logic [2*ROOT_W-1:0] rad_q;
  logic [ROOT_W+2:0]   rem_q;
  logic [ROOT_W-1:0]   root_q;
  logic [ROOT_W+2:0]   r2, trial;
  logic                ge;

  // Bring down two radicand bits and try the next root bit
  assign r2    = {rem_q[ROOT_W:0], rad_q[2*ROOT_W-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign ge    = r2 >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == SCNT_W'(ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[2*ROOT_W-3:0], 2'b00};
      rem_q  <= ge ? (r2 - trial) : r2;
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

/* rtl/qgi_div.sv */
// Restoring divider for 2^61 / magnitude, one quotient bit per cycle.
module qgi_div import qgi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ROOT_W-1:0] den_i,
  output logic              done_o,
  output logic [RCP_W-1:0]  quot_o
);

  logic              busy_q, done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [ROOT_W-1:0] den_q;
  logic [ROOT_W-1:0] rem_q;
  logic [RCP_W-1:0]  quot_q;
  logic [ROOT_W:0]   r2;
  logic              ge;

  // The dividend has a single one in its top bit
  assign r2 = {rem_q, cnt_q == '0};
  assign ge = r2 >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? ROOT_W'(r2 - {1'b0, den_q}) : r2[ROOT_W-1:0];
      quot_q <= {quot_q[RCP_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

/* rtl/qgi_dpath.sv */
// Datapath: attitude state, arithmetic units, output register and time step.
module qgi_dpath import qgi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [RATE_W-1:0] rate_roll_i,
  input  logic [RATE_W-1:0] rate_pitch_i,
  input  logic [RATE_W-1:0] rate_yaw_i,
  input  logic              cfg_we_i,
  input  logic [TS_W-1:0]   cfg_data_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [QW-1:0]     out_w_o,
  output logic [QW-1:0]     out_x_o,
  output logic [QW-1:0]     out_y_o,
  output logic [QW-1:0]     out_z_o,
  output logic              out_fell_o
);

  logic [TS_W-1:0]   ts_q;
  logic [RATE_W-1:0] rate_q [3];
  logic [A_W-1:0]    a_q;
  logic [H_W-1:0]    hmag_q [3];
  logic              hneg_q [3];
  logic [QW-1:0]     quat_q [4];
  logic [QW-1:0]     u_q [4];
  logic [ACC_W-1:0]  acc_q;
  logic [SUM_W-1:0]  sum_q;
  logic              fell_q;
  logic              out_valid_q;
  logic [QW-1:0]     out_q [4];
  logic              out_fell_q;

  logic [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [MP_W-1:0]   mul_p;
  logic              mul_done, sqrt_done, div_done;
  logic              mul_start, sqrt_start, div_start;
  logic [ROOT_W-1:0] root;
  logic [RCP_W-1:0]  recip;

  term_t             t;
  logic [1:0]        axis;
  logic [1:0]        comp;
  logic [TM_W-1:0]   tm;
  logic              tsub;
  logic [ACC_W-1:0]  base, nacc;

  assign t    = term_sel(cmd_i.idx);
  assign axis = cmd_i.idx[1:0];
  assign comp = cmd_i.idx[1:0];

  // Multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_RT: begin
        mul_a = MA_W'(mag32(rate_q[axis]));
        mul_b = MB_W'(ts_q);
      end
      OP_HD: begin
        mul_a = MA_W'(a_q);
        mul_b = MB_W'(DEG_TO_RAD_Q32);
      end
      OP_TERM: begin
        mul_a = MA_W'(mag32(quat_q[t.src]));
        mul_b = MB_W'(hmag_q[t.axis]);
      end
      OP_SQ: begin
        mul_a = MA_W'(mag32(u_q[comp]));
        mul_b = MB_W'(mag32(u_q[comp]));
      end
      OP_NORM: begin
        mul_a = MA_W'(mag32(u_q[comp]));
        mul_b = recip;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_start  = cmd_i.start && (cmd_i.op != OP_SQRT) && (cmd_i.op != OP_DIV);
  assign sqrt_start = cmd_i.start && (cmd_i.op == OP_SQRT);
  assign div_start  = cmd_i.start && (cmd_i.op == OP_DIV);

  qgi_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  qgi_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   ({1'b0, sum_q}),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  qgi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .den_i   (root),
    .done_o  (div_done),
    .quot_o  (recip)
  );

  // Signed accumulation of one update term
  assign tm   = mul_p[TM_W+29:30];
  assign tsub = t.sub ^ quat_q[t.src][QW-1] ^ hneg_q[t.axis];
  assign base = t.first ? {{(ACC_W-QW){quat_q[t.dst][QW-1]}}, quat_q[t.dst]} : acc_q;
  assign nacc = tsub ? (base - ACC_W'(tm)) : (base + ACC_W'(tm));

  // Time step, attitude state, fallback flag and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q        <= TIME_STEP_RESET;
      quat_q[0]   <= QUAT_ONE;
      quat_q[1]   <= '0;
      quat_q[2]   <= '0;
      quat_q[3]   <= '0;
      fell_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ts_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        fell_q <= 1'b0;
      end
      if (cmd_i.wb && (cmd_i.op == OP_NORM)) begin
        quat_q[comp] <= sat_mag(mul_p[RCP_W+31:32], u_q[comp][QW-1]);
      end
      if (cmd_i.fall) begin
        quat_q[0] <= QUAT_ONE;
        quat_q[1] <= '0;
        quat_q[2] <= '0;
        quat_q[3] <= '0;
        fell_q    <= 1'b1;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working values of one item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rate_q[0] <= rate_roll_i;
      rate_q[1] <= rate_pitch_i;
      rate_q[2] <= rate_yaw_i;
    end
    if (cmd_i.wb) begin
      case (cmd_i.op)
        OP_RT: a_q <= mul_p[A_W+17:18];
        OP_HD: begin
          hmag_q[axis] <= mul_p[H_W+32:33];
          hneg_q[axis] <= rate_q[axis][RATE_W-1];
        end
        OP_TERM: begin
          acc_q <= nacc;
          if (t.last) begin
            u_q[t.dst] <= sat_acc(nacc);
          end
        end
        OP_SQ: sum_q <= ((comp == 2'd0) ? '0 : sum_q) + SUM_W'(mul_p[63:2]);
        default: ;
      endcase
    end
    if (cmd_i.finish) begin
      out_q[0]   <= quat_q[0];
      out_q[1]   <= quat_q[1];
      out_q[2]   <= quat_q[2];
      out_q[3]   <= quat_q[3];
      out_fell_q <= fell_q;
    end
  end

  // Status back to the controller
  always_comb begin
    case (cmd_i.op)
      OP_SQRT: sts_o.done = sqrt_done;
      OP_DIV:  sts_o.done = div_done;
      default: sts_o.done = mul_done;
    endcase
    sts_o.low_mag  = sum_q <= MIN_MAG_SQ;
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_w_o     = out_q[0];
  assign out_x_o     = out_q[1];
  assign out_y_o     = out_q[2];
  assign out_z_o     = out_q[3];
  assign out_fell_o  = out_fell_q;

`ifndef SYNTHESIS
  // The multiplier reports completion for a single cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) mul_done |=> !mul_done)
    else $error("multiplier done lasted more than one cycle");

  // Identity falls back only on a small sum of squares
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.fall |-> sts_o.low_mag)
    else $error("fallback without a small magnitude");

  // A beat flagged as fallback carries the identity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_q && out_fell_q) |->
      (out_q[0] == QUAT_ONE) && (out_q[1] == '0) && (out_q[2] == '0) && (out_q[3] == '0))
    else $error("fallback beat is not the identity");

  // A new result is never loaded over one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      cmd_i.finish |-> (!out_valid_q || out_ready_i))
    else $error("output beat overwritten");
`endif

endmodule

/* rtl/qgi_ctrl.sv */
// Controller: sequences the arithmetic steps of one attitude update.
module qgi_ctrl import qgi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_HALF  = 4'd1;
  localparam logic [3:0] S_TERM  = 4'd2;
  localparam logic [3:0] S_SQ    = 4'd3;
  localparam logic [3:0] S_CHECK = 4'd4;
  localparam logic [3:0] S_SQRT  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_NORM  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       wait_q, wait_d;
  logic       unit_step;
  logic       last;
  logic [3:0] next_state;
  logic [2:0] op_sel;
  logic [3:0] idx_sel;

  // Operation, index and successor of each unit state
  always_comb begin
    op_sel     = OP_RT;
    idx_sel    = '0;
    unit_step  = 1'b1;
    last       = 1'b1;
    next_state = S_IDLE;
    case (state_q)
      S_HALF: begin
        op_sel     = cnt_q[0] ? OP_HD : OP_RT;
        idx_sel    = {2'b00, cnt_q[2:1]};
        last       = cnt_q == 4'd5;
        next_state = S_TERM;
      end
      S_TERM: begin
        op_sel     = OP_TERM;
        idx_sel    = cnt_q;
        last       = cnt_q == 4'd11;
        next_state = S_SQ;
      end
      S_SQ: begin
        op_sel     = OP_SQ;
        idx_sel    = cnt_q;
        last       = cnt_q == 4'd3;
        next_state = S_CHECK;
      end
      S_SQRT: begin
        op_sel     = OP_SQRT;
        next_state = S_DIV;
      end
      S_DIV: begin
        op_sel     = OP_DIV;
        next_state = S_NORM;
      end
      S_NORM: begin
        op_sel     = OP_NORM;
        idx_sel    = cnt_q;
        last       = cnt_q == 4'd3;
        next_state = S_OUT;
      end
      default: unit_step = 1'b0;
    endcase
  end

  // State transitions and handshakes with the units
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    wait_d      = wait_q;
    in_ready_o  = state_q == S_IDLE;
    cmd_o       = '0;
    cmd_o.op    = op_sel;
    cmd_o.idx   = idx_sel;
    if (unit_step) begin
      if (!wait_q) begin
        cmd_o.start = 1'b1;
        wait_d      = 1'b1;
      end else if (sts_i.done) begin
        cmd_o.wb = 1'b1;
        wait_d   = 1'b0;
        if (last) begin
          cnt_d   = '0;
          state_d = next_state;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_o.load = 1'b1;
            cnt_d      = '0;
            state_d    = S_HALF;
          end
        end
        S_CHECK: begin
          if (sts_i.low_mag) begin
            cmd_o.fall = 1'b1;
            state_d    = S_OUT;
          end else begin
            state_d = S_SQRT;
          end
        end
        S_OUT: begin
          if (sts_i.out_free) begin
            cmd_o.finish = 1'b1;
            state_d      = S_IDLE;
          end
        end
        default: state_d = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      wait_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      wait_q  <= wait_d;
    end
  end

endmodule

/* rtl/quaternion_gyro_integrate.sv */
// Quaternion attitude integrator from gyro rates, top level.
//
// Input stream: each beat carries rate_roll, rate_pitch and rate_yaw in
// degrees per second, signed Q16.16. Output stream: each beat carries the
// updated quaternion w, x, y, z in signed Q2.30, and tuser is set when the
// magnitude was at most 0.01 and the identity was used instead.
// The cfg channel writes the time step (unsigned Q0.32 seconds); it is
// always ready. The user must write it only while the block is idle; the
// block itself does not enforce this. One input beat gives exactly one
// output beat. Output valid rises after the update is worked through: 26
// multiplications through one serial multiplier (8 bits per cycle), a
// square root, a reciprocal division and the control states; with the
// identity fallback the square root, division and normalisation are
// skipped. The next beat can be accepted as soon as output valid rises.
// One item is worked at a time; s_axis_tready is high while the block is
// idle, also while a finished beat waits.
// After reset the quaternion is the identity and the time step is about
// 5 ms. A stalled receiver holds the output beat; the next item's result
// waits in the attitude state until the output register is free.
module quaternion_gyro_integrate import qgi_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [3*RATE_W-1:0] s_axis_tdata,  // rate_roll, rate_pitch, rate_yaw
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [4*QW-1:0]     m_axis_tdata,  // out_w, out_x, out_y, out_z
  output logic                m_axis_tuser,  // fell_back
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [TS_W-1:0]     cfg_data_i
);

  cmd_t          cmd;
  sts_t          sts;
  logic [QW-1:0] w, x, y, z;

  assign cfg_ready_o = 1'b1;

  qgi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  qgi_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .rate_roll_i  (s_axis_tdata[RATE_W-1:0]),
    .rate_pitch_i (s_axis_tdata[2*RATE_W-1:RATE_W]),
    .rate_yaw_i   (s_axis_tdata[3*RATE_W-1:2*RATE_W]),
    .cfg_we_i     (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_w_o      (w),
    .out_x_o      (x),
    .out_y_o      (y),
    .out_z_o      (z),
    .out_fell_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {z, y, x, w};

endmodule
